@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tgc_pkg.sv @@
package tgc_pkg;

    // Default width of the wrapping time base
    localparam int TGC_TIME_BITS = 32;

    // Configuration register indexes
    localparam logic [1:0] REG_NOISE_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_FIRST_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_SECOND_TIMEOUT = 2'd2;

    // Reset values of the timeouts (ms)
    localparam logic [15:0] NOISE_TIMEOUT_RST  = 16'd100;
    localparam logic [15:0] FIRST_TIMEOUT_RST  = 16'd100;
    localparam logic [15:0] SECOND_TIMEOUT_RST = 16'd200;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_FIRST  = 3'd1,
        ST_NOISY  = 3'd2,
        ST_WAIT   = 3'd3,
        ST_SINGLE = 3'd4,
        ST_DOUBLE = 3'd5
    } tgc_state_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_SINGLE = 2'd1,
        CMD_DOUBLE = 2'd2
    } tgc_cmd_t;

    typedef struct packed {
        logic [15:0] noise;
        logic [15:0] first;
        logic [15:0] second;
    } tgc_timeouts_t;

    typedef struct packed {
        tgc_cmd_t cmd;
        logic     idle;
    } tgc_result_t;

endpackage

@@ sv/tgc_cfg_regs.sv @@
module tgc_cfg_regs
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    output tgc_pkg::tgc_timeouts_t timeouts
);
    import tgc_pkg::*;

    tgc_timeouts_t timeouts_reg;
    tgc_timeouts_t timeouts_next;

    // Register write decode; unused index is dropped
    always_comb
    begin
        timeouts_next = timeouts_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NOISE_TIMEOUT:  timeouts_next.noise  = cfg_data;
                REG_FIRST_TIMEOUT:  timeouts_next.first  = cfg_data;
                REG_SECOND_TIMEOUT: timeouts_next.second = cfg_data;
                default:            timeouts_next = timeouts_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeouts_reg.noise  <= NOISE_TIMEOUT_RST;
            timeouts_reg.first  <= FIRST_TIMEOUT_RST;
            timeouts_reg.second <= SECOND_TIMEOUT_RST;
        end
        else
        begin
            timeouts_reg <= timeouts_next;
        end
    end

    assign timeouts = timeouts_reg;

endmodule

@@ sv/tgc_fsm.sv @@
module tgc_fsm
#(
    parameter int TIME_BITS = tgc_pkg::TGC_TIME_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   tap,
    input  logic [31:0]            now_ms,
    input  tgc_pkg::tgc_timeouts_t timeouts,
    output tgc_pkg::tgc_result_t   result,
    output tgc_pkg::tgc_state_t    state
);
    import tgc_pkg::*;

    // Width for widening the input stamp, and for the timeout compare
    localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int CMP_BITS  = (TIME_BITS > 16) ? TIME_BITS : 16;

    tgc_state_t           state_reg;
    tgc_state_t           state_next;
    logic [TIME_BITS-1:0] change_time_reg;
    logic [TIME_BITS-1:0] change_time_next;

    logic [WIDE_BITS-1:0] now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [15:0]          limit;
    logic                 expired;
    tgc_cmd_t             cmd;

    // Wrapping elapsed time against the timeout of the current state
    assign now_wide = WIDE_BITS'(now_ms);
    assign now_t    = now_wide[TIME_BITS-1:0];
    assign elapsed  = now_t - change_time_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_NOISY: limit = timeouts.noise;
            ST_WAIT:  limit = timeouts.second;
            default:  limit = timeouts.first;
        endcase
    end

    assign expired = CMP_BITS'(elapsed) >= CMP_BITS'(limit);

    // Next state, restart time and command
    always_comb
    begin
        state_next       = state_reg;
        change_time_next = change_time_reg;
        cmd              = CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tap)
                    state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                if (tap)
                    state_next = ST_NOISY;
                else if (expired)
                    state_next = ST_WAIT;
            end
            ST_NOISY:
            begin
                if (tap)
                    change_time_next = now_t;
                else if (expired)
                    state_next = ST_IDLE;
            end
            ST_WAIT:
            begin
                if (tap)
                    state_next = ST_DOUBLE;
                else if (expired)
                    state_next = ST_SINGLE;
            end
            ST_SINGLE:
            begin
                cmd        = CMD_SINGLE;
                state_next = ST_IDLE;
            end
            ST_DOUBLE:
            begin
                cmd        = CMD_DOUBLE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_next != state_reg)
            change_time_next = now_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            change_time_reg <= '0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            change_time_reg <= change_time_next;
        end
    end

    assign result.cmd  = cmd;
    assign result.idle = (state_next == ST_IDLE);
    assign state       = state_reg;

endmodule

@@ sv/tap_gesture_classifier.sv @@
// Single/double tap classifier.
// Input channel: in_valid / in_stall carry one poll item (tap_seen, now_ms).
// Output channel: out_valid / out_stall carry one result item per poll
// (command, idle). Both sides accept at a rising edge with valid high and
// stall low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 noise,
// 1 first, 2 second timeout, ms); other indexes are ignored. Write only
// while no item is in flight.
// Flow: an accepted item lands in the input register, and its result moves
// into the output register, raising out_valid, once that register is free or
// being drained.
// Throughput: one item per cycle unless out_stall holds a full output register;
// the state update (one subtract and one compare against the selected timeout) is combinational.
// Stall: when out_stall holds a full output register, the input register
// holds too and in_stall rises while it is occupied; nothing is dropped.
// Reset: state idle, last change time zero, timeouts 100/100/200 ms, both
// pipeline registers empty.
module tap_gesture_classifier
#(
    parameter int TIME_BITS = tgc_pkg::TGC_TIME_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tap_seen,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  command,
    output logic        idle,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tgc_pkg::*;

`include "assert_macros.svh"

    logic          in_valid_reg;
    logic          in_valid_next;
    logic          tap_reg;
    logic [31:0]   now_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    tgc_result_t   result_reg;
    tgc_result_t   result;
    tgc_timeouts_t timeouts;
    tgc_state_t    fsm_state;
    logic          advance;
    logic          step;
    logic          in_accept;
    logic          out_event;
    logic          single_step;
    logic          double_step;
    logic          single_out;
    logic          double_out;
    logic          out_held;

    tgc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timeouts  (timeouts)
    );

    tgc_fsm #(.TIME_BITS(TIME_BITS)) u_fsm
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .tap      (tap_reg),
        .now_ms   (now_reg),
        .timeouts (timeouts),
        .result   (result),
        .state    (fsm_state)
    );

    // Pipeline flow: output slot free or being drained
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tap_reg <= tap_seen;
            now_reg <= now_ms;
        end
        if (step)
            result_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign command   = result_reg.cmd;
    assign idle      = result_reg.idle;

    // Terms used by the checks below
    assign out_event   = out_valid_reg && (result_reg.cmd != CMD_NONE);
    assign single_step = step && (fsm_state == ST_SINGLE);
    assign double_step = step && (fsm_state == ST_DOUBLE);
    assign single_out  = out_valid_reg && (result_reg.cmd == CMD_SINGLE);
    assign double_out  = out_valid_reg && (result_reg.cmd == CMD_DOUBLE);
    assign out_held    = in_valid_reg && out_valid_reg && out_stall;

    // An event command always leaves the machine idle
    `ASSERT_IMPLIES(a_cmd_idle, clk, rst_n, out_event, result_reg.idle, "event without idle")
    // Stepping an event state produces that command next cycle
    `ASSERT_NEXT(a_single_cmd, clk, rst_n, single_step, single_out, "single event lost")
    `ASSERT_NEXT(a_double_cmd, clk, rst_n, double_step, double_out, "double event lost")
    // A held result must block the input register
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_held, in_stall && !step, "result overwritten")

endmodule

@@ sim/tap_gesture_classifier_test.sv @@
module tap_gesture_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tgc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    // Index past the last register: the block must ignore writes to it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic        tap;
        logic [31:0] stamp;
    } poll_item_t;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        tap_seen = 1'b0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  command;
    logic        idle;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Stimulus and scoreboard bookkeeping
    poll_item_t  poll_q[$];
    poll_item_t  next_poll;
    tgc_result_t pending_verdicts[$];
    tgc_result_t want;
    logic [31:0] clock_ms = '0;
    int unsigned items_built = 0;
    int unsigned polls_offered = 0;
    int unsigned polls_taken = 0;
    int unsigned verdicts_seen = 0;
    int unsigned verdicts_acked = 0;
    int unsigned singles_seen = 0;
    int unsigned doubles_seen = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    // Local copy of the classifier state and timeouts
    tgc_state_t    cls_state = ST_IDLE;
    logic [31:0]   cls_changed = '0;
    tgc_timeouts_t cls_tmo = '{NOISE_TIMEOUT_RST, FIRST_TIMEOUT_RST, SECOND_TIMEOUT_RST};

    tap_gesture_classifier u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tap_seen  (tap_seen),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .command   (command),
        .idle      (idle),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned draw_wait();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic report_error(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] ERROR: %s", $time, what);
    endtask

    // Next-state and command for one poll; queues the expected result
    task automatic classify_poll(input logic tap, input logic [31:0] stamp);
        tgc_state_t  nxt;
        tgc_cmd_t    cmd;
        logic [31:0] since;
        tgc_result_t r;
        nxt = cls_state;
        cmd = CMD_NONE;
        since = stamp - cls_changed;   // wraps modulo 2^32
        case (cls_state)
            ST_IDLE:
                if (tap) nxt = ST_FIRST;
            ST_FIRST:
                if (tap) nxt = ST_NOISY;
                else if (since >= 32'(cls_tmo.first)) nxt = ST_WAIT;
            ST_NOISY:
                if (tap) cls_changed = stamp;
                else if (since >= 32'(cls_tmo.noise)) nxt = ST_IDLE;
            ST_WAIT:
                if (tap) nxt = ST_DOUBLE;
                else if (since >= 32'(cls_tmo.second)) nxt = ST_SINGLE;
            ST_SINGLE:
            begin
                cmd = CMD_SINGLE;
                nxt = ST_IDLE;
            end
            ST_DOUBLE:
            begin
                cmd = CMD_DOUBLE;
                nxt = ST_IDLE;
            end
            default:
                nxt = ST_IDLE;
        endcase
        if (nxt != cls_state)
        begin
            cls_state = nxt;
            cls_changed = stamp;
        end
        r.cmd = cmd;
        r.idle = (cls_state == ST_IDLE);
        pending_verdicts.push_back(r);
    endtask

    // Sample config writes, accepted polls and accepted results
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NOISE_TIMEOUT:  cls_tmo.noise  = cfg_data;
                    REG_FIRST_TIMEOUT:  cls_tmo.first  = cfg_data;
                    REG_SECOND_TIMEOUT: cls_tmo.second = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                verdicts_seen++;
                if (command == CMD_SINGLE) singles_seen++;
                if (command == CMD_DOUBLE) doubles_seen++;
                if (pending_verdicts.size() == 0)
                    report_error($sformatf("result with nothing pending: command %0d idle %0b",
                                           command, idle));
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (command !== want.cmd || idle !== want.idle)
                        report_error($sformatf(
                            "result %0d: command %0d (exp %0d) idle %0b (exp %0b)",
                            verdicts_seen, command, want.cmd, idle, want.idle));
                end
            end
            if (in_valid && !in_stall)
            begin
                classify_poll(tap_seen, now_ms);
                polls_taken++;
            end
        end
    end

    // Poll driver: holds an item until taken, then waits a random gap
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && polls_taken != polls_offered))
        begin
            if (in_valid)
            begin
                if ($urandom_range(0, 49) == 0)
                    in_calm = !in_calm;
                gap_left = in_calm ? 0 : draw_wait();
            end
            if (gap_left > 0 || poll_q.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                next_poll = poll_q.pop_front();
                in_valid <= 1'b1;
                tap_seen <= next_poll.tap;
                now_ms <= next_poll.stamp;
                polls_offered++;
            end
        end
    end

    // Result receiver: stalls a random number of cycles after each item
    always @(negedge clk)
    begin
        if (verdicts_seen != verdicts_acked)
        begin
            verdicts_acked = verdicts_seen;
            if ($urandom_range(0, 49) == 0)
                out_calm = !out_calm;
            stall_left = out_calm ? 0 : draw_wait();
        end
        out_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at cycle limit: %0d polls taken, %0d results pending",
                 polls_taken, pending_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic add_poll_at(input logic tap, input logic [31:0] stamp);
        poll_item_t p;
        clock_ms = stamp;
        p.tap = tap;
        p.stamp = stamp;
        poll_q.push_back(p);
        items_built++;
    endtask

    task automatic add_poll(input logic tap, input logic [31:0] adv);
        add_poll_at(tap, clock_ms + adv);
    endtask

    // Tap-free polls covering at least span ms; often lands exactly on it
    task automatic quiet(input int unsigned span);
        int unsigned done;
        int unsigned adv;
        done = 0;
        while (done < span)
        begin
            adv = $urandom_range(1, span / 4 + 1);
            if ($urandom_range(0, 1) && adv > span - done)
                adv = span - done;
            add_poll(1'b0, adv);
            done += adv;
        end
    endtask

    // Three long quiet polls bring the machine back to idle from any state
    task automatic settle();
        int unsigned span;
        span = 32'(cls_tmo.noise) + 32'(cls_tmo.first) + 32'(cls_tmo.second) + 1;
        repeat (3) add_poll(1'b0, span);
    endtask

    task automatic build_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_built + count;
        while (items_built < stop_at)
        begin
            case ($urandom_range(0, 9))
                // single tap
                0, 1, 2:
                begin
                    add_poll(1'b1, $urandom_range(1, 1000));
                    quiet(32'(cls_tmo.first));
                    quiet(32'(cls_tmo.second));
                    add_poll(1'b0, 1);
                    add_poll(1'b0, 1);
                end
                // double tap; the event poll carries a random tap flag
                3, 4, 5:
                begin
                    add_poll(1'b1, $urandom_range(1, 1000));
                    quiet(32'(cls_tmo.first));
                    add_poll(1'b1, $urandom_range(0, 32'(cls_tmo.second) / 2));
                    add_poll(1'($urandom_range(0, 1)), $urandom_range(0, 50));
                end
                // burst of taps, then quiet until the noise timeout
                6, 7:
                begin
                    add_poll(1'b1, $urandom_range(1, 1000));
                    repeat ($urandom_range(1, 4))
                        add_poll(1'b1, $urandom_range(0, 32'(cls_tmo.noise) / 2 + 1));
                    quiet(32'(cls_tmo.noise));
                    add_poll(1'b0, 1);
                end
                // abandoned gesture
                8:
                begin
                    add_poll(1'b1, $urandom_range(1, 1000));
                    quiet(32'(cls_tmo.first) / 2);
                    settle();
                end
                // random taps with jumps anywhere in the time base
                default:
                begin
                    repeat ($urandom_range(3, 8))
                    begin
                        if ($urandom_range(0, 1))
                            add_poll_at(1'($urandom_range(0, 1)), $urandom());
                        else
                            add_poll(1'($urandom_range(0, 1)), $urandom_range(0, 300));
                    end
                    settle();
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timeouts(input logic [15:0] noise, input logic [15:0] first,
                                input logic [15:0] second);
        write_reg(REG_NOISE_TIMEOUT, noise);
        write_reg(REG_FIRST_TIMEOUT, first);
        write_reg(REG_SECOND_TIMEOUT, second);
    endtask

    // Wait until every poll is taken and every result checked
    task automatic drain();
        while (poll_q.size() != 0 || polls_taken != polls_offered
               || pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_timeout(input int unsigned range_sel);
        case (range_sel)
            0:       return 16'($urandom_range(0, 4));
            1:       return 16'($urandom_range(20, 400));
            default: return 16'($urandom_range(1000, 65535));
        endcase
    endfunction

    // Main sequence
    initial
    begin
        int unsigned range_sel;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset timeouts: single tap across the time wrap, exact boundaries
        add_poll_at(1'b1, 32'hFFFF_FFF0);
        add_poll_at(1'b0, 32'h0000_0053);
        add_poll_at(1'b0, 32'h0000_0054);
        add_poll_at(1'b0, 32'h0000_011B);
        add_poll_at(1'b0, 32'h0000_011C);
        add_poll_at(1'b1, 32'h0000_011D);
        // double tap, tap right after the first window
        add_poll_at(1'b1, 32'h0000_0200);
        add_poll_at(1'b0, 32'h0000_0264);
        add_poll_at(1'b1, 32'h0000_0265);
        add_poll_at(1'b0, 32'h0000_0266);
        // noisy burst with a timer restart
        add_poll_at(1'b1, 32'h0000_0300);
        add_poll_at(1'b1, 32'h0000_0301);
        add_poll_at(1'b1, 32'h0000_0360);
        add_poll_at(1'b0, 32'h0000_03C3);
        add_poll_at(1'b0, 32'h0000_03C4);
        add_poll_at(1'b0, 32'hFFFF_FFFF);
        drain();

        // Zero timeouts expire on the first tap-free poll
        set_timeouts('0, '0, '0);
        write_reg(REG_UNUSED, 16'hFFFF);
        add_poll_at(1'b1, 32'd5);
        add_poll_at(1'b0, 32'd5);
        add_poll_at(1'b0, 32'd5);
        add_poll_at(1'b0, 32'd5);
        add_poll_at(1'b1, 32'd6);
        add_poll_at(1'b1, 32'd6);
        add_poll_at(1'b0, 32'd6);
        drain();

        // Largest timeouts, one below and exactly at the first limit, then at the second
        set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_poll_at(1'b1, 32'h0000_0000);
        add_poll_at(1'b0, 32'h0000_FFFE);
        add_poll_at(1'b0, 32'h0000_FFFF);
        add_poll_at(1'b0, 32'h0001_FFFE);
        add_poll_at(1'b0, 32'h0001_FFFF);
        build_random(100);

        // Random gestures under a spread of timeout settings
        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                3: set_timeouts(pick_timeout($urandom_range(0, 2)),
                                pick_timeout($urandom_range(0, 2)),
                                pick_timeout($urandom_range(0, 2)));
                4: set_timeouts(NOISE_TIMEOUT_RST, FIRST_TIMEOUT_RST, SECOND_TIMEOUT_RST);
                default:
                begin
                    range_sel = p % 3;
                    set_timeouts(pick_timeout(range_sel), pick_timeout(range_sel),
                                 pick_timeout(range_sel));
                end
            endcase
            if (p % 2)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            build_random(170);
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Checked %0d polls against %0d results over 9 timeout settings",
                 polls_taken, verdicts_seen);
        $display("Gestures classified: %0d single, %0d double; %0d mismatches",
                 singles_seen, doubles_seen, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
